/* rtl/core/pdld_pkg.sv */
package pdld_pkg;

	// full-scale level and the hold time that reaches it
	localparam int unsigned LEVEL_W      = 12;
	localparam int unsigned SEG_W        = 16;
	localparam int unsigned HOLD_W       = 10;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 12'd4095;
	localparam logic [31:0] HOLD_FULL_MS = 32'd1000;

	// per-channel hold measurement handed from the state stage to the level stage
	typedef struct packed {
		logic              hit;
		logic [1:0]        channel;
		logic              saturated;
		logic [HOLD_W-1:0] hold_ms;
	} hold_t;

	// seven-segment code of one decimal digit
	function automatic logic [7:0] seg_code(input logic [3:0] digit);
		logic [7:0] code;
		case (digit)
			4'd0: code = 8'h3F;
			4'd1: code = 8'h06;
			4'd2: code = 8'h5B;
			4'd3: code = 8'h4F;
			4'd4: code = 8'h66;
			4'd5: code = 8'h6D;
			4'd6: code = 8'h7D;
			4'd7: code = 8'h27;
			4'd8: code = 8'h7F;
			4'd9: code = 8'h67;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

endpackage

/* rtl/core/pdld_hold.sv */
module pdld_hold #(
	parameter int unsigned CHANNELS = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	input  logic              advance,
	input  logic [1:0]        channel,
	input  logic [31:0]       now_ms,
	output pdld_pkg::hold_t   hold
);
	import pdld_pkg::*;

	logic [CHANNELS-1:0] armed_q;
	logic [31:0]         start_q [CHANNELS];
	logic [CHANNELS-1:0] sel;
	logic [31:0]         start_sel;
	logic [31:0]         hold_full;
	logic                armed_hit;

	// channel decode and selected start time
	always_comb begin
		start_sel = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			sel[i] = (int'(channel) == i);
			if (sel[i]) begin
				start_sel = start_q[i];
			end
		end
		armed_hit = |(sel & armed_q);
	end

	// hold time, modulo the timer wrap
	assign hold_full = now_ms - start_sel;

	always_comb begin
		hold.hit       = valid && armed_hit;
		hold.channel   = channel;
		hold.saturated = (hold_full > HOLD_FULL_MS);
		hold.hold_ms   = hold_full[HOLD_W-1:0];
	end

	// arm on the first edge, disarm on the second
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
		end else if (valid && advance) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (sel[i]) begin
					armed_q[i] <= !armed_q[i];
				end
			end
		end
	end

	// start stamp captured when a channel arms
	always_ff @(posedge clk) begin
		if (valid && advance) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (sel[i] && !armed_q[i]) begin
					start_q[i] <= now_ms;
				end
			end
		end
	end

endmodule

/* rtl/core/pdld_level.sv */
module pdld_level (
	input  pdld_pkg::hold_t                        hold,
	output logic [pdld_pkg::LEVEL_W-1:0]           level,
	output logic [pdld_pkg::SEG_W-1:0]             segment_pattern
);
	import pdld_pkg::*;

	// 2^22 * 19 / 200 approximated from above, exact floor(19*hold/200) for holds up to 1023
	localparam logic [28:0] FRAC_RECIP = 29'd398468;

	logic [28:0] frac_prod;
	logic [6:0]  frac;
	logic [18:0] pct_prod;
	logic [15:0] dec_prod;
	logic [6:0]  pct;
	logic [3:0]  tens;
	logic [6:0]  ones_wide;
	logic [3:0]  ones;

	// level = 4*hold + floor(19*hold/200), exact for holds up to the full-scale time
	always_comb begin
		frac_prod = 29'(hold.hold_ms) * FRAC_RECIP;
		frac      = frac_prod[28:22];
		if (hold.saturated) begin
			level = LEVEL_MAX;
		end else begin
			level = {hold.hold_ms, 2'b00} + LEVEL_W'(frac);
		end
	end

	// percentage digits: tens = level*10/4096, ones = level*100/4096 mod 10
	always_comb begin
		pct_prod  = 19'(level) * 19'd100;
		dec_prod  = 16'(level) * 16'd10;
		pct       = pct_prod[18:12];
		tens      = dec_prod[15:12];
		ones_wide = pct - 7'(tens) * 7'd10;
		ones      = ones_wide[3:0];
		segment_pattern = {seg_code(ones), seg_code(tens)};
	end

endmodule

/* rtl/core/press_duration_level_display.sv */
// Press-duration level display. Each switch edge arrives as one transaction on the
// slave stream: the channel (0 red, 1 green, 2 blue) in s_tuser and the millisecond
// time stamp in s_tdata. An edge on an unarmed channel arms it and gives no result;
// an edge on an armed channel disarms it and gives one result with the new 12-bit
// level, min(hold*4095/1000, 4095), and the seven-segment pattern of its percentage
// (ones digit in bits 27:20 of m_tdata, tens digit in bits 19:12). Channel codes at
// or above CHANNELS are dropped. One transaction is accepted per cycle while m_tready
// does not hold the stages back. A result passes the input register, the hold stage
// with the per-channel arm/start state, and the output register after the level and
// digit logic. Edges to the same channel may follow back to back.
module press_duration_level_display #(
	parameter int unsigned CHANNELS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] now_ms
	input  logic [1:0]  s_tuser,   // [1:0] channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [11:0] level, [27:12] segment_pattern, [31:28] zero
	output logic [1:0]  m_tuser    // [1:0] channel_out
);
	import pdld_pkg::*;

	logic                 valid_s1;
	logic [1:0]           channel_s1;
	logic [31:0]          now_s1;
	logic                 valid_s2;
	hold_t                hold_s2;
	hold_t                hold_next;
	logic                 ready_s2;
	logic                 out_ready;
	logic                 m_valid_q;
	logic [LEVEL_W-1:0]   level_q;
	logic [SEG_W-1:0]     seg_q;
	logic [1:0]           channel_q;
	logic [LEVEL_W-1:0]   level_next;
	logic [SEG_W-1:0]     seg_next;

	// stall chain, each stage moves when the next has room
	assign out_ready = !m_valid_q || m_tready;
	assign ready_s2  = !valid_s2 || out_ready;
	assign s_tready  = !valid_s1 || ready_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			channel_s1 <= s_tuser;
			now_s1     <= s_tdata;
		end
	end

	// per-channel state and hold time
	pdld_hold #(
		.CHANNELS(CHANNELS)
	) u_hold (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid_s1),
		.advance(ready_s2),
		.channel(channel_s1),
		.now_ms (now_s1),
		.hold   (hold_next)
	);

	// hold register, arming edges become bubbles here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= hold_next.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && hold_next.hit) begin
			hold_s2 <= hold_next;
		end
	end

	// level and digit patterns
	pdld_level u_level (
		.hold           (hold_s2),
		.level          (level_next),
		.segment_pattern(seg_next)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_ready) begin
			m_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s2) begin
			level_q   <= level_next;
			seg_q     <= seg_next;
			channel_q <= hold_s2.channel;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0000, seg_q, level_q};
	assign m_tuser  = channel_q;

endmodule
